[rtl/assert_macros.svh]
// assertion macros for the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked on the next clock
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// consequent checked on the same clock
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent checked on the next clock, also while reset is low
`define ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/atkd_pkg.sv]
// shared types and constants for the atkinson dither unit
package atkd_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_INDEX_W    = 2;
    localparam int WIDTH_RESET    = 800;
    localparam int HEIGHT_RESET   = 480;
    localparam int PIX_W          = 8;
    localparam int PIX_MAX        = 255;
    localparam int THRESHOLD      = 128;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } reg_index_t;

    typedef logic signed [7:0] err_t;
    typedef logic signed [4:0] share_t;

    typedef struct packed {
        logic first_col;
        logic has_right;
        logic has_right2;
        logic has_below;
        logic has_below2;
        logic last_px;
    } pix_ctl_t;

    typedef struct packed {
        logic next_we;
        err_t next_data;
        logic second_we;
        err_t second_data;
    } line_wr_t;

endpackage

[rtl/atkd_line_store.sv]
// error line stores for the next row and the row two below, with clear sweep and bypass
module atkd_line_store #(
    parameter int MAX_WIDTH = atkd_pkg::MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         restart,
    output logic                         busy,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output atkd_pkg::err_t               rd_next,
    output atkd_pkg::err_t               rd_second,
    input  atkd_pkg::line_wr_t           wr,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_next_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_second_addr
);

    localparam int XW = $clog2(MAX_WIDTH);

    atkd_pkg::err_t next_mem   [MAX_WIDTH];
    atkd_pkg::err_t second_mem [MAX_WIDTH];

    logic             busy_reg;
    logic [XW-1:0]    clr_cnt_reg;
    atkd_pkg::err_t   next_rd_reg;
    atkd_pkg::err_t   second_rd_reg;
    logic             next_byp_reg;
    logic             second_byp_reg;
    atkd_pkg::err_t   next_byp_data_reg;
    atkd_pkg::err_t   second_byp_data_reg;

    // clear sweep after reset and after a register write
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + XW'(1);
            if (clr_cnt_reg == XW'(MAX_WIDTH - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            next_mem[clr_cnt_reg]   <= '0;
            second_mem[clr_cnt_reg] <= '0;
        end else begin
            if (wr.next_we) begin
                next_mem[wr_next_addr] <= wr.next_data;
            end
            if (wr.second_we) begin
                second_mem[wr_second_addr] <= wr.second_data;
            end
        end
    end

    // read with capture of a write to the same entry at the same edge
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            next_rd_reg         <= next_mem[rd_addr];
            second_rd_reg       <= second_mem[rd_addr];
            next_byp_data_reg   <= wr.next_data;
            second_byp_data_reg <= wr.second_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_byp_reg   <= 1'b0;
            second_byp_reg <= 1'b0;
        end else if (rd_en) begin
            next_byp_reg   <= wr.next_we && (wr_next_addr == rd_addr);
            second_byp_reg <= wr.second_we && (wr_second_addr == rd_addr);
        end
    end

    assign busy      = busy_reg;
    assign rd_next   = next_byp_reg ? next_byp_data_reg : next_rd_reg;
    assign rd_second = second_byp_reg ? second_byp_data_reg : second_rd_reg;

endmodule

[rtl/atkd_diffuse.sv]
// threshold, error share and diffusion update, bit packer and output register
module atkd_diffuse #(
    parameter int MAX_WIDTH = atkd_pkg::MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         restart,
    input  logic                         load,
    input  logic [atkd_pkg::PIX_W-1:0]   pix_in,
    input  logic [$clog2(MAX_WIDTH)-1:0] x_in,
    input  atkd_pkg::pix_ctl_t           ctl_in,
    output logic                         stage_free,
    input  atkd_pkg::err_t               rd_next,
    input  atkd_pkg::err_t               rd_second,
    output atkd_pkg::line_wr_t           wr,
    output logic [$clog2(MAX_WIDTH)-1:0] wr_next_addr,
    output logic [$clog2(MAX_WIDTH)-1:0] wr_second_addr,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_packed_bits,
    output logic                         m_frame_end
);

    localparam int XW = $clog2(MAX_WIDTH);

    logic                       s1_valid_reg;
    logic [atkd_pkg::PIX_W-1:0] s1_pix_reg;
    logic [XW-1:0]              s1_x_reg;
    atkd_pkg::pix_ctl_t         s1_ctl_reg;

    atkd_pkg::err_t ahead0_reg;
    atkd_pkg::err_t ahead1_reg;
    atkd_pkg::err_t pend_reg;
    logic           hold_valid_reg;
    logic [XW-1:0]  hold_addr_reg;
    atkd_pkg::err_t hold_val_reg;
    logic [7:0]     shift_reg;
    logic [2:0]     cnt_reg;
    logic           m_valid_reg;
    logic [7:0]     m_packed_reg;
    logic           m_frame_end_reg;

    atkd_pkg::err_t      cur_next;
    logic signed [10:0]  acc_sum;
    logic [7:0]          level;
    logic                black;
    logic signed [8:0]   err_val;
    logic signed [8:0]   err_adj;
    atkd_pkg::share_t    q;
    atkd_pkg::err_t      q8;
    atkd_pkg::err_t      q_below;
    atkd_pkg::err_t      base;
    logic                emit;
    logic                commit;
    logic [7:0]          shift_next;
    logic [3:0]          cnt_next;
    logic [2:0]          pad;

    always_comb begin
        // the hold register is newer than the store for its column
        cur_next = (hold_valid_reg && (hold_addr_reg == s1_x_reg)) ? hold_val_reg : rd_next;
        acc_sum  = $signed({3'b000, s1_pix_reg}) + $signed({{3{ahead0_reg[7]}}, ahead0_reg})
                 + $signed({{3{cur_next[7]}}, cur_next});
        if (acc_sum < 0) begin
            level = 8'd0;
        end else if (acc_sum > 11'sd255) begin
            level = 8'(atkd_pkg::PIX_MAX);
        end else begin
            level = acc_sum[7:0];
        end
        black   = level < 8'(atkd_pkg::THRESHOLD);
        err_val = black ? $signed({1'b0, level}) : $signed({1'b0, level}) - 9'sd255;
        // divide by eight toward zero
        err_adj = err_val[8] ? err_val + 9'sd7 : err_val;
        q       = err_adj[7:3];
        q8      = {{3{q[4]}}, q};
        q_below = s1_ctl_reg.has_below ? q8 : '0;
        base    = rd_second + pend_reg + q_below;

        emit    = (cnt_reg == 3'd7) || s1_ctl_reg.last_px;
        commit  = s1_valid_reg && (!emit || !m_valid_reg || m_ready);

        shift_next = {shift_reg[6:0], black};
        cnt_next   = {1'b0, cnt_reg} + 4'd1;
        pad        = 3'(4'd8 - cnt_next);
    end

    always_comb begin
        wr.next_we     = commit && hold_valid_reg;
        wr.next_data   = hold_val_reg
                       + ((!s1_ctl_reg.first_col && s1_ctl_reg.has_below) ? q8 : '0);
        wr.second_we   = commit;
        wr.second_data = s1_ctl_reg.has_below2 ? q8 : '0;
    end

    assign wr_next_addr   = hold_addr_reg;
    assign wr_second_addr = s1_x_reg;
    assign stage_free     = !s1_valid_reg || commit;

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            s1_valid_reg <= 1'b0;
        end else if (load) begin
            s1_valid_reg <= 1'b1;
        end else if (commit) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_pix_reg <= pix_in;
            s1_x_reg   <= x_in;
            s1_ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            ahead0_reg     <= '0;
            ahead1_reg     <= '0;
            pend_reg       <= '0;
            hold_valid_reg <= 1'b0;
            hold_addr_reg  <= '0;
            hold_val_reg   <= '0;
            shift_reg      <= '0;
            cnt_reg        <= '0;
        end else if (commit) begin
            hold_valid_reg <= 1'b1;
            hold_addr_reg  <= s1_x_reg;
            hold_val_reg   <= base;
            pend_reg       <= (s1_ctl_reg.has_right && s1_ctl_reg.has_below) ? q8 : '0;
            ahead0_reg     <= s1_ctl_reg.has_right ? ahead1_reg + q8 : '0;
            ahead1_reg     <= s1_ctl_reg.has_right2 ? q8 : '0;
            if (emit) begin
                shift_reg <= '0;
                cnt_reg   <= '0;
            end else begin
                shift_reg <= shift_next;
                cnt_reg   <= cnt_next[2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            m_valid_reg <= 1'b0;
        end else if (commit && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit && emit) begin
            m_packed_reg    <= shift_next << pad;
            m_frame_end_reg <= s1_ctl_reg.last_px;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_packed_bits = m_packed_reg;
    assign m_frame_end   = m_frame_end_reg;

endmodule

[rtl/atkinson_dither_1bit_unit.sv]
// top level of the atkinson error diffusion dither, 8-bit gray to packed 1-bit pixels
// a completed byte goes valid from the output register, set when its last pixel leaves the stage register
// throughput: one pixel per cycle, a pixel that ends a byte waits only while m_ready holds
// the previous byte; reset and every register write start a clear sweep over all MAX_WIDTH entries
// of both line stores, s_ready stays low during the sweep
// registers reset to 800 by 480, saturated to MAX_WIDTH by MAX_HEIGHT
module atkinson_dither_1bit_unit #(
    parameter int MAX_WIDTH  = atkd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = atkd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [atkd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [atkd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [atkd_pkg::PIX_W-1:0]       s_gray_pixel,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_packed_bits,
    output logic                             m_frame_end
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = DW + 1;
    localparam int RW = HW + 1;
    localparam int W_RESET = (atkd_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                  : atkd_pkg::WIDTH_RESET;
    localparam int H_RESET = (atkd_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                    : atkd_pkg::HEIGHT_RESET;

    logic [DW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [XW-1:0] col_reg;
    logic [YW-1:0] row_reg;

    logic               restart;
    logic               busy;
    logic               stage_free;
    logic               accept;
    logic [CW-1:0]      col_p1;
    logic [CW-1:0]      col_p2;
    logic [RW-1:0]      row_p1;
    logic [RW-1:0]      row_p2;
    logic               last_col;
    logic               last_row;
    atkd_pkg::pix_ctl_t ctl;
    atkd_pkg::err_t     rd_next;
    atkd_pkg::err_t     rd_second;
    atkd_pkg::line_wr_t wr;
    logic [XW-1:0]      wr_next_addr;
    logic [XW-1:0]      wr_second_addr;

    // register write decode with zero and oversize values clamped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DW'(W_RESET);
            height_reg <= HW'(H_RESET);
        end else if (cfg_we) begin
            unique case (cfg_index)
                atkd_pkg::REG_IMAGE_WIDTH: begin
                    if (cfg_wdata == '0) begin
                        width_reg <= DW'(1);
                    end else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) begin
                        width_reg <= DW'(MAX_WIDTH);
                    end else begin
                        width_reg <= DW'(cfg_wdata);
                    end
                end
                atkd_pkg::REG_IMAGE_HEIGHT: begin
                    if (cfg_wdata == '0) begin
                        height_reg <= HW'(1);
                    end else if (32'(cfg_wdata) > 32'(MAX_HEIGHT)) begin
                        height_reg <= HW'(MAX_HEIGHT);
                    end else begin
                        height_reg <= HW'(cfg_wdata);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign restart = cfg_we && ((cfg_index == atkd_pkg::REG_IMAGE_WIDTH)
                             || (cfg_index == atkd_pkg::REG_IMAGE_HEIGHT));

    assign s_ready = !busy && stage_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        col_p1   = CW'(col_reg) + CW'(1);
        col_p2   = CW'(col_reg) + CW'(2);
        row_p1   = RW'(row_reg) + RW'(1);
        row_p2   = RW'(row_reg) + RW'(2);
        last_col = col_p1 >= CW'(width_reg);
        last_row = row_p1 >= RW'(height_reg);

        ctl.first_col  = (col_reg == '0);
        ctl.has_right  = !last_col;
        ctl.has_right2 = col_p2 < CW'(width_reg);
        ctl.has_below  = !last_row;
        ctl.has_below2 = row_p2 < RW'(height_reg);
        ctl.last_px    = last_col && last_row;
    end

    // raster position of the next item
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_p1[YW-1:0];
            end else begin
                col_reg <= col_p1[XW-1:0];
            end
        end
    end

    atkd_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .restart        (restart),
        .busy           (busy),
        .rd_en          (accept),
        .rd_addr        (col_reg),
        .rd_next        (rd_next),
        .rd_second      (rd_second),
        .wr             (wr),
        .wr_next_addr   (wr_next_addr),
        .wr_second_addr (wr_second_addr)
    );

    atkd_diffuse #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_diffuse (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .restart        (restart),
        .load           (accept),
        .pix_in         (s_gray_pixel),
        .x_in           (col_reg),
        .ctl_in         (ctl),
        .stage_free     (stage_free),
        .rd_next        (rd_next),
        .rd_second      (rd_second),
        .wr             (wr),
        .wr_next_addr   (wr_next_addr),
        .wr_second_addr (wr_second_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_packed_bits  (m_packed_bits),
        .m_frame_end    (m_frame_end)
    );

endmodule

[rtl/atkd_port_checker.sv]
// port level checks for the atkinson dither unit and their binding
`include "assert_macros.svh"

module atkd_port_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_we,
    input logic [atkd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [7:0]                       m_packed_bits,
    input logic                             m_frame_end
);

    logic cfg_restart;

    assign cfg_restart = cfg_we && ((cfg_index == atkd_pkg::REG_IMAGE_WIDTH)
                                 || (cfg_index == atkd_pkg::REG_IMAGE_HEIGHT));

    `ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable({m_packed_bits, m_frame_end}))
    `ASSERT_RESET(a_reset_sweep, !aresetn, !s_ready && !m_valid)
    `ASSERT_NEXT(a_cfg_sweep, cfg_restart, !s_ready && !m_valid)
    `ASSERT_SAME(a_out_from_item, $rose(m_valid), $past(s_valid && s_ready, 2))

endmodule

bind atkinson_dither_1bit_unit atkd_port_checker u_port_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_packed_bits (m_packed_bits),
    .m_frame_end   (m_frame_end)
);
